// ===== rtl/jols_pkg.sv =====
// jols_pkg: shared types and constants of the json object line sanitizer
// no dependencies; imported by json_object_line_sanitizer_unit
`timescale 1ns / 1ps

package jols_pkg;

    // object buffer capacity in bytes
    localparam int OBJECT_BYTES = 62;
    localparam int ADDR_W       = (OBJECT_BYTES > 1) ? $clog2(OBJECT_BYTES) : 1;
    localparam int LEN_W        = $clog2(OBJECT_BYTES + 1);

    localparam int DEPTH_W = 16;
    localparam int COUNT_W = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // characters the parser reacts to
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } jols_state_t;

endpackage

// ===== rtl/jols_ram.sv =====
// jols_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; contents are undefined until written
`timescale 1ns / 1ps

module jols_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/json_object_line_sanitizer_unit.sv =====
// json_object_line_sanitizer_unit: keeps complete top-level json objects of a byte stream
// depends on jols_pkg and jols_ram (object buffer)
//
// result: a result beat is in the output register in the cycle after its input beat is taken
// throughput: one input beat per cycle while no object closes and the output is not stalled;
//   a closing brace of an object holding L buffered bytes blocks the input until the buffer
//   ram read port has drained them one byte per cycle (plus any output stall)
// reset: synchronous, active-low aresetn clears parser state, counters and the output
//   valid; the object buffer is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module json_object_line_sanitizer_unit
    import jols_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_stream

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [23:8] kept_count, [39:24] dropped_count
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser    // [0] byte_valid, [1] end_report
);

    // ---------------------------------------------------------------------------------------
    // state
    // ---------------------------------------------------------------------------------------
    jols_state_t        state_reg, state_next;

    logic               quoted_reg, quoted_next;
    logic               escape_reg, escape_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               open_reg, open_next;
    logic [LEN_W-1:0]   obj_len_reg, obj_len_next;
    logic               line_has_reg, line_has_next;
    logic [COUNT_W-1:0] kept_reg, kept_next;
    logic [COUNT_W-1:0] dropped_reg, dropped_next;

    // drain pointer into the object buffer
    logic [ADDR_W-1:0]  drain_idx_reg, drain_idx_next;
    logic [ADDR_W-1:0]  drain_end_reg, drain_end_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_bvalid_reg, out_bvalid_next;
    logic               out_last_reg, out_last_next;
    logic               out_endrep_reg, out_endrep_next;
    logic [COUNT_W-1:0] out_kept_reg, out_kept_next;
    logic [COUNT_W-1:0] out_drop_reg, out_drop_next;

    // ---------------------------------------------------------------------------------------
    // handshake and helpers
    // ---------------------------------------------------------------------------------------
    logic               out_free;
    logic               s_acc;
    logic               out_load;
    logic               start_drain;
    logic               drain_last;
    logic [LEN_W-1:0]   len_after;
    logic [COUNT_W-1:0] kept_inc;
    logic [COUNT_W-1:0] dropped_inc;

    // buffer ram port signals
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    // a beat may only be taken when any result it makes has room in the output register
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign kept_inc    = (kept_reg == COUNT_MAX) ? kept_reg : kept_reg + 1'b1;
    assign dropped_inc = (dropped_reg == COUNT_MAX) ? dropped_reg : dropped_reg + 1'b1;
    assign drain_last  = (drain_idx_reg == drain_end_reg);

    jols_ram #(
        .WIDTH (8),
        .DEPTH (OBJECT_BYTES)
    ) u_obj_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_drain) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free && drain_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // parser, buffer access and result generation
    // ---------------------------------------------------------------------------------------
    always_comb begin
        quoted_next     = quoted_reg;
        escape_next     = escape_reg;
        depth_next      = depth_reg;
        open_next       = open_reg;
        obj_len_next    = obj_len_reg;
        line_has_next   = line_has_reg;
        kept_next       = kept_reg;
        dropped_next    = dropped_reg;
        drain_idx_next  = drain_idx_reg;
        drain_end_next  = drain_end_reg;
        len_after       = obj_len_reg;

        ram_we          = 1'b0;
        ram_waddr       = obj_len_reg[ADDR_W-1:0];
        ram_wdata       = s_tdata;
        ram_re          = 1'b0;
        ram_raddr       = ADDR_W'(drain_idx_reg + 1'b1);

        start_drain     = 1'b0;
        out_load        = 1'b0;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_last_next   = out_last_reg;
        out_endrep_next = out_endrep_reg;
        out_kept_next   = out_kept_reg;
        out_drop_next   = out_drop_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tlast) begin
                        // end of stream: single report beat, then back to reset state
                        out_load        = 1'b1;
                        out_byte_next   = line_has_reg ? CH_LF : 8'h00;
                        out_bvalid_next = line_has_reg;
                        out_last_next   = 1'b1;
                        out_endrep_next = 1'b1;
                        out_kept_next   = kept_reg;
                        out_drop_next   = (open_reg && depth_reg != '0) ? dropped_inc
                                                                         : dropped_reg;
                        quoted_next     = 1'b0;
                        escape_next     = 1'b0;
                        depth_next      = '0;
                        open_next       = 1'b0;
                        obj_len_next    = '0;
                        line_has_next   = 1'b0;
                        kept_next       = '0;
                        dropped_next    = '0;
                    end else if (s_tdata == CH_CR) begin
                        // carriage return is swallowed everywhere
                    end else if (depth_reg == '0) begin
                        if (s_tdata == CH_LBRACE) begin
                            // new object starts at buffer entry zero
                            quoted_next    = 1'b0;
                            escape_next    = 1'b0;
                            depth_next     = DEPTH_W'(1);
                            open_next      = 1'b1;
                            ram_we         = 1'b1;
                            ram_waddr      = '0;
                            obj_len_next   = LEN_W'(1);
                        end else if (s_tdata == CH_LF && line_has_reg) begin
                            out_load        = 1'b1;
                            out_byte_next   = CH_LF;
                            out_bvalid_next = 1'b1;
                            out_last_next   = 1'b1;
                            out_endrep_next = 1'b0;
                            out_kept_next   = kept_reg;
                            out_drop_next   = dropped_reg;
                            line_has_next   = 1'b0;
                        end
                    end else begin
                        // inside an object: buffer while there is room, parse always
                        if (obj_len_reg < LEN_W'(OBJECT_BYTES)) begin
                            ram_we    = 1'b1;
                            len_after = obj_len_reg + 1'b1;
                        end
                        obj_len_next = len_after;

                        if (quoted_reg) begin
                            if (escape_reg) begin
                                escape_next = 1'b0;
                            end else if (s_tdata == CH_BSLASH) begin
                                escape_next = 1'b1;
                            end else if (s_tdata == CH_QUOTE) begin
                                quoted_next = 1'b0;
                            end
                        end else if (s_tdata == CH_QUOTE) begin
                            quoted_next = 1'b1;
                        end else if (s_tdata == CH_LBRACE) begin
                            if (depth_reg != DEPTH_MAX) begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end else if (s_tdata == CH_RBRACE) begin
                            depth_next = depth_reg - 1'b1;
                            if (depth_reg == DEPTH_W'(1)) begin
                                // object complete: optional comma now, buffer drains next
                                kept_next      = kept_inc;
                                line_has_next  = 1'b1;
                                open_next      = 1'b0;
                                obj_len_next   = '0;
                                start_drain    = 1'b1;
                                ram_re         = 1'b1;
                                ram_raddr      = '0;
                                drain_idx_next = '0;
                                drain_end_next = ADDR_W'(len_after - 1'b1);
                                if (line_has_reg) begin
                                    out_load        = 1'b1;
                                    out_byte_next   = CH_COMMA;
                                    out_bvalid_next = 1'b1;
                                    out_last_next   = 1'b0;
                                    out_endrep_next = 1'b0;
                                    out_kept_next   = kept_inc;
                                    out_drop_next   = dropped_reg;
                                end
                            end
                        end
                    end
                end
            end
            ST_DRAIN: begin
                // read data of the current index is waiting on the ram output
                if (out_free) begin
                    out_load        = 1'b1;
                    out_byte_next   = ram_rdata;
                    out_bvalid_next = 1'b1;
                    out_last_next   = drain_last;
                    out_endrep_next = 1'b0;
                    out_kept_next   = kept_reg;
                    out_drop_next   = dropped_reg;
                    if (!drain_last) begin
                        ram_re         = 1'b1;
                        drain_idx_next = ADDR_W'(drain_idx_reg + 1'b1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // ---------------------------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            quoted_reg    <= 1'b0;
            escape_reg    <= 1'b0;
            depth_reg     <= '0;
            open_reg      <= 1'b0;
            obj_len_reg   <= '0;
            line_has_reg  <= 1'b0;
            kept_reg      <= '0;
            dropped_reg   <= '0;
            drain_idx_reg <= '0;
            drain_end_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            quoted_reg    <= quoted_next;
            escape_reg    <= escape_next;
            depth_reg     <= depth_next;
            open_reg      <= open_next;
            obj_len_reg   <= obj_len_next;
            line_has_reg  <= line_has_next;
            kept_reg      <= kept_next;
            dropped_reg   <= dropped_next;
            drain_idx_reg <= drain_idx_next;
            drain_end_reg <= drain_end_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_last_reg   <= out_last_next;
        out_endrep_reg <= out_endrep_next;
        out_kept_reg   <= out_kept_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_drop_reg, out_kept_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_endrep_reg, out_bvalid_reg};

    // ---------------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------------
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> kept_reg == '0 && dropped_reg == '0 && depth_reg == '0)
        else $error("end of stream did not return counters and depth to zero");

    a_drain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> drain_idx_reg <= drain_end_reg)
        else $error("drain pointer ran past the end of the object");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        obj_len_reg <= LEN_W'(OBJECT_BYTES))
        else $error("object length beyond buffer capacity");

    a_open_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg == (depth_reg != '0))
        else $error("object open flag and brace depth disagree");

    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_endrep_reg |-> out_last_reg)
        else $error("end report beat not marked last");

endmodule
